FILE: hdl/lpc_pkg.sv
// Shared constants and request/response types of the LRU plan cache.
`default_nettype none

package lpc_pkg;

  localparam int ENTRIES    = 32;
  localparam int POS_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int KEY_W      = 64;
  localparam int COST_W     = 32;
  localparam int SUM_W      = 37;
  localparam int CTR_W      = 64;
  localparam int MAXE_W     = 6;
  localparam int MAXS_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // request operations
  localparam logic OP_USE   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SCRATCH = 1'd1;

  localparam logic [MAXE_W-1:0] MAXE_RESET = 6'd32;
  localparam logic [MAXS_W-1:0] MAXS_RESET = 32'd67108864;

  // recency order memory access
  typedef struct packed {
    logic [POS_W-1:0] rd_addr;
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [POS_W-1:0] wr_data;
  } ord_req_t;

  // key/cost memory access
  typedef struct packed {
    logic [POS_W-1:0]  rd_addr;
    logic              wr_en;
    logic [POS_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  wr_key;
    logic [COST_W-1:0] wr_cost;
  } ent_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [COST_W-1:0] cost;
  } ent_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/lpc_if.sv
// Channel interfaces of the LRU plan cache: use/clear requests, results, configuration.
`default_nettype none

interface lpc_in_if;
  import lpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [KEY_W-1:0]  key_tag;
  logic [COST_W-1:0] entry_cost;
  modport source (output valid, op, key_tag, entry_cost, input ready);
  modport sink   (input valid, op, key_tag, entry_cost, output ready);
endinterface

interface lpc_out_if;
  import lpc_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [POS_W-1:0] slot;
  logic [CNT_W-1:0] evicted;
  logic [CNT_W-1:0] entry_count;
  logic [SUM_W-1:0] scratch_total;
  logic [CTR_W-1:0] build_count;
  logic [CTR_W-1:0] hit_count;
  logic [CTR_W-1:0] use_count;
  modport source (output valid, hit, slot, evicted, entry_count, scratch_total,
                  build_count, hit_count, use_count, input ready);
  modport sink   (input valid, hit, slot, evicted, entry_count, scratch_total,
                  build_count, hit_count, use_count, output ready);
endinterface

interface lpc_cfg_if;
  import lpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/lpc_order_ram.sv
// Recency order memory: position to slot, one read and one write port, identity after reset.
`default_nettype none

module lpc_order_ram (
  input  logic                     clk,
  input  logic                     rst,
  input  lpc_pkg::ord_req_t        req,
  output logic [lpc_pkg::POS_W-1:0] rd_slot
);
  import lpc_pkg::*;

  logic [POS_W-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  logic [POS_W-1:0]   rd_data;
  logic [POS_W-1:0]   rd_addr;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
    rd_addr <= req.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      rd_vld <= vld[req.rd_addr];
    end
  end

  // an unwritten position still holds its own index
  assign rd_slot = rd_vld ? rd_data : rd_addr;

endmodule

`default_nettype wire

FILE: hdl/lpc_entry_ram.sv
// Key and cost memory indexed by physical slot, registered read.
`default_nettype none

module lpc_entry_ram (
  input  logic              clk,
  input  lpc_pkg::ent_req_t req,
  output lpc_pkg::ent_rsp_t rsp
);
  import lpc_pkg::*;

  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [COST_W-1:0] cost_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr]  <= req.wr_key;
      cost_mem[req.wr_addr] <= req.wr_cost;
    end
    rsp.key  <= key_mem[req.rd_addr];
    rsp.cost <= cost_mem[req.rd_addr];
  end

endmodule

`default_nettype wire

FILE: hdl/lpc_seq.sv
// Sequencer: key scan with move to front, insertion, eviction walk, counters and result register.
`default_nettype none

module lpc_seq (
  input  logic                       clk,
  input  logic                       rst,
  lpc_in_if.sink                     req,
  lpc_out_if.source                  rsp,
  input  logic [lpc_pkg::MAXE_W-1:0] max_entries,
  input  logic [lpc_pkg::MAXS_W-1:0] max_scratch,
  output lpc_pkg::ord_req_t          ord_req,
  input  logic [lpc_pkg::POS_W-1:0]  ord_slot,
  output lpc_pkg::ent_req_t          ent_req,
  input  lpc_pkg::ent_rsp_t          ent_rsp
);
  import lpc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FRONT = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  live;
  logic [SUM_W-1:0]  sum;
  logic [CTR_W-1:0]  builds;
  logic [CTR_W-1:0]  hits;
  logic [CTR_W-1:0]  uses;
  logic [CNT_W-1:0]  rd_pos;
  logic [CNT_W-1:0]  ev_pos;
  logic              st1_v;
  logic              st2_v;
  logic              e1_v;
  logic              e2_v;
  logic              out_valid;

  logic [KEY_W-1:0]  key_r;
  logic [COST_W-1:0] cost_r;
  logic [POS_W-1:0]  last_pos;
  logic [POS_W-1:0]  st1_pos;
  logic [POS_W-1:0]  st2_pos;
  logic [POS_W-1:0]  st2_slot;
  logic [POS_W-1:0]  prev_slot;
  logic [POS_W-1:0]  tslot;
  logic [COST_W-1:0] old_cost;
  logic              hit_f;
  logic [CNT_W-1:0]  evicted;

  logic              accept;
  logic              out_free;
  logic              sc_issue;
  logic              ev_issue;
  logic              match;
  logic              at_target;
  logic              drop;
  logic              ev_stop;
  logic              full;
  logic [CNT_W-1:0]  live_front;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign full       = (live == CNT_W'(ENTRIES));
  assign sc_issue   = (rd_pos <= {1'b0, last_pos});
  assign ev_issue   = (ev_pos != '0);
  assign match      = st2_v && ({1'b0, st2_pos} < live) && (ent_rsp.key == key_r);
  assign at_target  = st2_v && (match || (st2_pos == last_pos));
  assign drop       = e2_v && (live > CNT_W'(1)) &&
                      ((live > max_entries) || (sum > SUM_W'(max_scratch)));
  assign ev_stop    = (e2_v && !drop) || (!e1_v && !e2_v && !ev_issue);
  assign live_front = (!hit_f && !full) ? live + CNT_W'(1) : live;

  // memory requests
  always_comb begin
    ord_req         = '0;
    ent_req         = '0;
    ent_req.wr_key  = key_r;
    ent_req.wr_cost = cost_r;
    ent_req.wr_addr = tslot;
    unique case (state)
      S_IDLE: begin
        ord_req.rd_addr = '0;
      end
      S_SCAN: begin
        ord_req.rd_addr = rd_pos[POS_W-1:0];
        ent_req.rd_addr = ord_slot;
        ord_req.wr_en   = st2_v && (st2_pos != '0);
        ord_req.wr_addr = st2_pos;
        ord_req.wr_data = prev_slot;
      end
      S_FRONT: begin
        ord_req.wr_en   = 1'b1;
        ord_req.wr_addr = '0;
        ord_req.wr_data = tslot;
        ent_req.wr_en   = !hit_f;
      end
      S_EVICT: begin
        ord_req.rd_addr = ev_pos[POS_W-1:0];
        ent_req.rd_addr = ord_slot;
      end
      S_DONE: begin
        ord_req.rd_addr = '0;
      end
      default: begin
        ord_req.rd_addr = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      sum       <= '0;
      builds    <= '0;
      hits      <= '0;
      uses      <= '0;
      rd_pos    <= '0;
      ev_pos    <= '0;
      st1_v     <= 1'b0;
      st2_v     <= 1'b0;
      e1_v      <= 1'b0;
      e2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.op == OP_CLEAR) begin
              live  <= '0;
              sum   <= '0;
              state <= S_DONE;
            end else begin
              st1_v  <= 1'b1;
              st2_v  <= 1'b0;
              rd_pos <= CNT_W'(1);
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (at_target) begin
            st1_v <= 1'b0;
            st2_v <= 1'b0;
            state <= S_FRONT;
          end else begin
            st2_v <= st1_v;
            if (sc_issue) begin
              st1_v  <= 1'b1;
              rd_pos <= rd_pos + CNT_W'(1);
            end else begin
              st1_v <= 1'b0;
            end
          end
        end
        S_FRONT: begin
          if (hit_f) begin
            hits <= hits + CTR_W'(1);
          end else begin
            builds <= builds + CTR_W'(1);
            if (full) begin
              sum <= sum - SUM_W'(old_cost) + SUM_W'(cost_r);
            end else begin
              live <= live + CNT_W'(1);
              sum  <= sum + SUM_W'(cost_r);
            end
          end
          uses   <= uses + CTR_W'(1);
          ev_pos <= live_front - CNT_W'(1);
          e1_v   <= 1'b0;
          e2_v   <= 1'b0;
          state  <= S_EVICT;
        end
        S_EVICT: begin
          if (drop) begin
            sum  <= sum - SUM_W'(ent_rsp.cost);
            live <= live - CNT_W'(1);
          end
          if (ev_stop) begin
            e1_v  <= 1'b0;
            e2_v  <= 1'b0;
            state <= S_DONE;
          end else begin
            e2_v <= e1_v;
            if (ev_issue) begin
              e1_v   <= 1'b1;
              ev_pos <= ev_pos - CNT_W'(1);
            end else begin
              e1_v <= 1'b0;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key_r    <= req.key_tag;
          cost_r   <= req.entry_cost;
          hit_f    <= 1'b0;
          st1_pos  <= '0;
          last_pos <= full ? POS_W'(ENTRIES - 1) : live[POS_W-1:0];
          if (req.op == OP_CLEAR) begin
            evicted <= live;
            tslot   <= '0;
          end else begin
            evicted <= '0;
          end
        end
      end
      S_SCAN: begin
        st2_pos  <= st1_pos;
        st2_slot <= ord_slot;
        if (sc_issue) begin
          st1_pos <= rd_pos[POS_W-1:0];
        end
        if (st2_v) begin
          prev_slot <= st2_slot;
        end
        if (at_target) begin
          hit_f    <= match;
          tslot    <= st2_slot;
          old_cost <= ent_rsp.cost;
        end
      end
      S_FRONT: begin
        if (!hit_f && full) begin
          evicted <= CNT_W'(1);
        end
      end
      S_EVICT: begin
        if (drop) begin
          evicted <= evicted + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          rsp.hit           <= hit_f;
          rsp.slot          <= tslot;
          rsp.evicted       <= evicted;
          rsp.entry_count   <= live;
          rsp.scratch_total <= sum;
          rsp.build_count   <= builds;
          rsp.hit_count     <= hits;
          rsp.use_count     <= uses;
        end
      end
      default: begin
        hit_f <= 1'b0;
      end
    endcase
  end

  assign rsp.valid = out_valid;

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (live == '0) |-> (sum == '0))
    else $error("empty table with nonzero scratch total");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while previous transaction in progress");

  a_scan_write_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && ord_req.wr_en |-> (ord_req.wr_addr <= last_pos))
    else $error("order shift wrote past target position");

endmodule

`default_nettype wire

FILE: hdl/lru_plan_cache_with_byte_budget.sv
// Top level of the LRU plan cache with entry limit and scratch byte budget.
//
// Channels: req (sink) carries one use or clear transaction: op, key_tag and
// entry_cost. rsp (source) returns exactly one result transaction per request:
// hit, slot, evicted, entry_count, scratch_total and the three wrapping
// counters. cfg (sink, always ready) writes max_entries (index 0) or
// max_scratch (index 1); write it only while no request is in flight.
// Sequencing: one request at a time. A clear goes straight to the result
// register. A use runs the key scan, which walks the recency memory one
// position a cycle up to the hit or the insertion position, moves that entry
// to the front, then runs the eviction walk, which drops one entry a cycle
// from the cold end. The next request is taken once the result is in the
// output register.
// Reset (rst, synchronous) empties the table, zeroes the totals and counters,
// restores the registers to 32 entries and 64 MiB, and returns the recency
// order to identity through per-position valid bits; no clearing pass.
// Stall: a finished result sits in the output register; while the receiver
// holds off, the sequencer waits with the next result and takes no request.
`default_nettype none

module lru_plan_cache_with_byte_budget (
  input  logic      clk,
  input  logic      rst,
  lpc_cfg_if.sink   cfg,
  lpc_in_if.sink    req,
  lpc_out_if.source rsp
);
  import lpc_pkg::*;

  logic [MAXE_W-1:0] max_entries;
  logic [MAXS_W-1:0] max_scratch;
  ord_req_t          ord_req;
  logic [POS_W-1:0]  ord_slot;
  ent_req_t          ent_req;
  ent_rsp_t          ent_rsp;

  // configuration registers: accept every write, drop unknown indexes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAXE_RESET;
      max_scratch <= MAXS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MAX_ENTRIES: max_entries <= cfg.data[MAXE_W-1:0];
        REG_MAX_SCRATCH: max_scratch <= cfg.data[MAXS_W-1:0];
        default: begin
          max_entries <= max_entries;
        end
      endcase
    end
  end

  // recency order: position 0 is the most recent entry
  lpc_order_ram u_order (
    .clk     (clk),
    .rst     (rst),
    .req     (ord_req),
    .rd_slot (ord_slot)
  );

  // keys and scratch costs by physical slot
  lpc_entry_ram u_entry (
    .clk (clk),
    .req (ent_req),
    .rsp (ent_rsp)
  );

  lpc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .max_entries (max_entries),
    .max_scratch (max_scratch),
    .ord_req     (ord_req),
    .ord_slot    (ord_slot),
    .ent_req     (ent_req),
    .ent_rsp     (ent_rsp)
  );

endmodule

`default_nettype wire
